>>> design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is high
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, held off while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Next-cycle implication that also holds through reset
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset check failed");

`endif

>>> design/ctnd_pkg.sv
// Types, constants and lookup functions of the coded-name decoder.
package ctnd_pkg;

  // Terminator codes
  localparam logic [7:0] CODE_END  = 8'hFF;
  localparam logic [7:0] CODE_STOP = 8'hF8;

  // Configuration register indexes
  localparam int          CFG_IDX_W    = 2;
  localparam logic [1:0]  REG_CAPACITY = 2'd0;
  localparam logic [1:0]  REG_SCAN     = 2'd1;
  localparam int          CFG_DATA_W   = 7;

  // Held-space counter width
  localparam int HOLD_W = 6;

  // Command queue depth (power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       name_start;
  } in_word_t;

  typedef struct packed {
    logic [6:0] ascii_char;
    logic       char_valid;
    logic       name_end;
  } out_word_t;

  typedef enum logic [1:0] {
    K_NONE,
    K_CHAR,
    K_ESC
  } cmd_kind_t;

  // One classified item handed from front to back
  typedef struct packed {
    logic [HOLD_W-1:0] spaces;  // held spaces sent before the body
    cmd_kind_t         kind;
    logic [7:0]        code;    // ASCII for a char, raw code for an escape
    logic              close;   // end marker follows
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SPACE,
    B_CHAR,
    B_ESC_OPEN,
    B_ESC_HI,
    B_ESC_LO,
    B_ESC_CLOSE,
    B_END
  } back_state_t;

  // Code to ASCII; zero marks a code with no character
  function automatic logic [7:0] code_map(input logic [6:0] code);
    logic [7:0] ch;
    case (code)
      7'd0:  ch = " ";
      7'd1:  ch = "e";
      7'd2:  ch = "t";
      7'd3:  ch = "a";
      7'd4:  ch = "o";
      7'd5:  ch = "i";
      7'd6:  ch = "n";
      7'd7:  ch = "s";
      7'd8:  ch = "r";
      7'd9:  ch = "h";
      7'd10: ch = "l";
      7'd11: ch = ".";
      7'd12: ch = "d";
      7'd13: ch = "u";
      7'd14: ch = "m";
      7'd15: ch = "c";
      7'd16: ch = "g";
      7'd17: ch = "y";
      7'd18: ch = "w";
      7'd19: ch = "f";
      7'd20: ch = "p";
      7'd21: ch = "b";
      7'd22: ch = "k";
      7'd24: ch = "A";
      7'd25: ch = "v";
      7'd26: ch = "I";
      7'd27: ch = "'";
      7'd28: ch = "T";
      7'd29: ch = "S";
      7'd30: ch = "M";
      7'd31: ch = ",";
      7'd32: ch = "D";
      7'd33: ch = "O";
      7'd34: ch = "W";
      7'd35: ch = "H";
      7'd36: ch = "Y";
      7'd37: ch = "E";
      7'd38: ch = "R";
      7'd41: ch = "G";
      7'd42: ch = "L";
      7'd43: ch = "C";
      7'd44: ch = "N";
      7'd45: ch = "B";
      7'd47: ch = "P";
      7'd48: ch = "-";
      7'd49: ch = "F";
      7'd50: ch = "z";
      7'd51: ch = "K";
      7'd52: ch = "j";
      7'd53: ch = "U";
      7'd54: ch = "x";
      7'd55: ch = "q";
      7'd56: ch = "0";
      7'd57: ch = "V";
      7'd58: ch = "2";
      7'd59: ch = "J";
      7'd60: ch = "#";
      7'd61: ch = "1";
      7'd62: ch = "Q";
      7'd63: ch = "Z";
      7'd65: ch = "3";
      7'd66: ch = "5";
      7'd67: ch = "&";
      7'd69: ch = "7";
      7'd70: ch = "X";
      7'd74: ch = "4";
      7'd78: ch = "6";
      7'd85: ch = "a";
      7'd87: ch = "8";
      7'd89: ch = "9";
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  // Lower-case hex digit
  function automatic logic [6:0] hex_digit(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'("0") + {4'd0, nib};
    end else begin
      ch = 8'("a") + {4'd0, nib} - 8'd10;
    end
    return ch[6:0];
  endfunction

endpackage

>>> design/ctnd_front.sv
// Front part: accepts coded bytes, tracks name counters, classifies each byte.
module ctnd_front #(
  parameter int MAX_CAPACITY = 56
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ctnd_pkg::in_word_t              in_data,
  input  logic [5:0]                      name_capacity,
  input  logic [6:0]                      scan_limit,
  input  logic                            q_full,
  output logic                            q_push,
  output ctnd_pkg::cmd_t                  q_cmd
);

  localparam int CW = $clog2(MAX_CAPACITY + 1);

  logic                        name_open, name_open_next;
  logic [6:0]                  bytes_seen, bytes_seen_next;
  logic [CW-1:0]               chars_written, chars_written_next;
  logic [ctnd_pkg::HOLD_W-1:0] held_spaces, held_spaces_next;

  logic                        accept;
  logic [CW:0]                 cap_x;
  logic                        open_base;
  logic [6:0]                  bs_base;
  logic [CW-1:0]               cw_base;
  logic [ctnd_pkg::HOLD_W-1:0] hs_base;
  logic [7:0]                  map_ch;
  logic                        limit_base;
  ctnd_pkg::cmd_t              cmd;

  // Take a byte whenever the queue has room
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Capacity saturated to the build limit
  always_comb begin
    if (int'(name_capacity) > MAX_CAPACITY) begin
      cap_x = (CW+1)'(MAX_CAPACITY);
    end else begin
      cap_x = (CW+1)'(name_capacity);
    end
  end

  // Counters as seen by this byte (a start flag clears them)
  assign open_base  = in_data.name_start || name_open;
  assign bs_base    = in_data.name_start ? 7'd0 : bytes_seen;
  assign cw_base    = in_data.name_start ? '0 : chars_written;
  assign hs_base    = in_data.name_start ? '0 : held_spaces;
  assign map_ch     = in_data.raw_byte[7] ? 8'd0 : ctnd_pkg::code_map(in_data.raw_byte[6:0]);
  assign limit_base = (bs_base >= scan_limit) ||
                      ({1'b0, cw_base} + (CW+1)'(1) >= cap_x);

  // Classify the byte and update the name counters
  always_comb begin
    name_open_next     = name_open;
    bytes_seen_next    = bytes_seen;
    chars_written_next = chars_written;
    held_spaces_next   = held_spaces;
    cmd                = '{spaces: '0, kind: ctnd_pkg::K_NONE, code: 8'd0, close: 1'b0};
    q_push             = 1'b0;
    if (accept) begin
      name_open_next     = open_base;
      bytes_seen_next    = bs_base;
      chars_written_next = cw_base;
      held_spaces_next   = hs_base;
      if (open_base) begin
        if (limit_base || in_data.raw_byte == ctnd_pkg::CODE_END ||
            in_data.raw_byte == ctnd_pkg::CODE_STOP) begin
          cmd.close        = 1'b1;
          name_open_next   = 1'b0;
          held_spaces_next = '0;
        end else begin
          if (map_ch == 8'(" ")) begin
            held_spaces_next   = hs_base + ctnd_pkg::HOLD_W'(1);
            chars_written_next = cw_base + CW'(1);
          end else if (map_ch != 8'd0) begin
            cmd.spaces         = hs_base;
            cmd.kind           = ctnd_pkg::K_CHAR;
            cmd.code           = map_ch;
            held_spaces_next   = '0;
            chars_written_next = cw_base + CW'(1);
          end else if ({1'b0, cw_base} + (CW+1)'(5) < cap_x) begin
            cmd.spaces         = hs_base;
            cmd.kind           = ctnd_pkg::K_ESC;
            cmd.code           = in_data.raw_byte;
            held_spaces_next   = '0;
            chars_written_next = cw_base + CW'(4);
          end
          bytes_seen_next = bs_base + 7'd1;
          // Limit reached after this byte: close at once
          if ((bytes_seen_next >= scan_limit) ||
              ({1'b0, chars_written_next} + (CW+1)'(1) >= cap_x)) begin
            cmd.close        = 1'b1;
            name_open_next   = 1'b0;
            held_spaces_next = '0;
          end
        end
        q_push = cmd.close || (cmd.kind != ctnd_pkg::K_NONE);
      end
    end
  end

  assign q_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      name_open     <= 1'b0;
      bytes_seen    <= 7'd0;
      chars_written <= '0;
      held_spaces   <= '0;
    end else begin
      name_open     <= name_open_next;
      bytes_seen    <= bytes_seen_next;
      chars_written <= chars_written_next;
      held_spaces   <= held_spaces_next;
    end
  end

endmodule

>>> design/ctnd_queue.sv
// Short command queue between the front and back parts.
module ctnd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ctnd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output ctnd_pkg::cmd_t pop_cmd,
  output logic           empty
);

  ctnd_pkg::cmd_t                  slots [ctnd_pkg::QUEUE_DEPTH];
  logic [ctnd_pkg::QPTR_W-1:0]     wr_ptr;
  logic [ctnd_pkg::QPTR_W-1:0]     rd_ptr;
  logic [ctnd_pkg::QPTR_W:0]       count;

  assign full    = (count == (ctnd_pkg::QPTR_W+1)'(ctnd_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = slots[rd_ptr];

  // Storage; push only happens when not full
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + ctnd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + ctnd_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (ctnd_pkg::QPTR_W+1)'(1);
        2'b01:   count <= count - (ctnd_pkg::QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> design/ctnd_back.sv
// Back part: expands queued commands into output words, one per cycle unless the output is stalled.
module ctnd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  ctnd_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output ctnd_pkg::out_word_t out_data
);

  ctnd_pkg::back_state_t       state, state_next;
  ctnd_pkg::cmd_t              cmd, cmd_next;
  logic [ctnd_pkg::HOLD_W-1:0] cnt, cnt_next;
  logic                        produce;
  logic                        emit;
  ctnd_pkg::out_word_t         word;

  // State that sends the body of a command (or its end marker)
  function automatic ctnd_pkg::back_state_t body_of(input ctnd_pkg::cmd_t c);
    ctnd_pkg::back_state_t s;
    case (c.kind)
      ctnd_pkg::K_CHAR: s = ctnd_pkg::B_CHAR;
      ctnd_pkg::K_ESC:  s = ctnd_pkg::B_ESC_OPEN;
      default:          s = ctnd_pkg::B_END;
    endcase
    return s;
  endfunction

  // Output register free at this edge
  assign produce = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    cmd_next   = cmd;
    cnt_next   = cnt;
    case (state)
      ctnd_pkg::B_IDLE: begin
        if (!q_empty) begin
          cmd_next   = q_cmd;
          cnt_next   = q_cmd.spaces;
          state_next = (q_cmd.spaces != '0) ? ctnd_pkg::B_SPACE : body_of(q_cmd);
        end
      end
      ctnd_pkg::B_SPACE: begin
        if (produce) begin
          cnt_next = cnt - ctnd_pkg::HOLD_W'(1);
          if (cnt == ctnd_pkg::HOLD_W'(1)) begin
            state_next = body_of(cmd);
          end
        end
      end
      ctnd_pkg::B_CHAR, ctnd_pkg::B_ESC_CLOSE: begin
        if (produce) begin
          state_next = cmd.close ? ctnd_pkg::B_END : ctnd_pkg::B_IDLE;
        end
      end
      ctnd_pkg::B_ESC_OPEN: begin
        if (produce) begin
          state_next = ctnd_pkg::B_ESC_HI;
        end
      end
      ctnd_pkg::B_ESC_HI: begin
        if (produce) begin
          state_next = ctnd_pkg::B_ESC_LO;
        end
      end
      ctnd_pkg::B_ESC_LO: begin
        if (produce) begin
          state_next = ctnd_pkg::B_ESC_CLOSE;
        end
      end
      ctnd_pkg::B_END: begin
        if (produce) begin
          state_next = ctnd_pkg::B_IDLE;
        end
      end
      default: state_next = ctnd_pkg::B_IDLE;
    endcase
  end

  // Outputs: pop and the word for this state
  always_comb begin
    q_pop = (state == ctnd_pkg::B_IDLE) && !q_empty;
    emit  = 1'b1;
    word  = '{ascii_char: 7'd0, char_valid: 1'b1, name_end: 1'b0};
    case (state)
      ctnd_pkg::B_SPACE:     word.ascii_char = 7'(" ");
      ctnd_pkg::B_CHAR:      word.ascii_char = cmd.code[6:0];
      ctnd_pkg::B_ESC_OPEN:  word.ascii_char = 7'("<");
      ctnd_pkg::B_ESC_HI:    word.ascii_char = ctnd_pkg::hex_digit(cmd.code[7:4]);
      ctnd_pkg::B_ESC_LO:    word.ascii_char = ctnd_pkg::hex_digit(cmd.code[3:0]);
      ctnd_pkg::B_ESC_CLOSE: word.ascii_char = 7'(">");
      ctnd_pkg::B_END: begin
        word.char_valid = 1'b0;
        word.name_end   = 1'b1;
      end
      default: begin
        emit            = 1'b0;
        word.char_valid = 1'b0;
      end
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctnd_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
    cmd <= cmd_next;
    cnt <= cnt_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (produce) begin
      out_valid <= emit;
    end
    if (produce) begin
      out_data <= word;
    end
  end

endmodule

>>> design/coded_text_name_decoder_top.sv
// Top level of the coded-name decoder: config registers, front, queue, back.
//
//   channel | direction | handshake         | word
//   in      | in        | in_valid/in_stall | in_word_t: raw_byte, name_start
//   out     | out       | out_valid/out_stall | out_word_t: ascii_char, char_valid, name_end
//   cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// The front classifies one byte per cycle while the two-entry command queue has room.
// The back loads a command while idle, then sends its output words one per cycle while
// the output register is free; held spaces and escapes expand into more than one word.
// Reset is synchronous; counters clear and no name is open afterwards.
// in_stall is high while the queue is full; out_stall holds the output register
// and, through the queue, eventually the input.
module coded_text_name_decoder_top #(
  parameter int MAX_CAPACITY = 56
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ctnd_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ctnd_pkg::out_word_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ctnd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ctnd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [5:0]     name_capacity;
  logic [6:0]     scan_limit;
  logic           q_push, q_full, q_pop, q_empty;
  ctnd_pkg::cmd_t push_cmd, pop_cmd;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      name_capacity <= 6'd40;
      scan_limit    <= 7'd80;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ctnd_pkg::REG_CAPACITY: name_capacity <= cfg_data[5:0];
        ctnd_pkg::REG_SCAN:     scan_limit    <= cfg_data[6:0];
        default:                ;
      endcase
    end
  end

  ctnd_front #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .name_capacity (name_capacity),
    .scan_limit    (scan_limit),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  ctnd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  ctnd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> design/ctnd_checker.sv
// Port-level checker for the coded-name decoder and its bind.
`include "assert_macros.svh"

module ctnd_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input ctnd_pkg::out_word_t out_data
);

  // A word is either a character or the end marker, never both
  `ASSERT_IMPL(a_word_kind, clk, rst, out_valid, out_data.char_valid != out_data.name_end)

  // The end marker carries a zero character
  `ASSERT_IMPL(a_end_zero, clk, rst, out_valid && out_data.name_end, out_data.ascii_char == 7'd0)

  // A stalled word stays put
  `ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))

  // Nothing is offered right after reset
  `ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, rst, !out_valid)

endmodule

bind coded_text_name_decoder_top ctnd_checker u_ctnd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
